// ----- rtl/ltrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltrc_pkg
// Shared types, register map and constants of the luma threshold ROI counter.
// ----------------------------------------------------------------------------
package ltrc_pkg;

  localparam int MAX_SIDE_DEFAULT = 4096;

  localparam int SIZE_W  = 13;
  localparam int POS_W   = 12;
  localparam int LEVEL_W = 8;
  localparam int TALLY_W = 25;
  localparam int SUM_W   = 18;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROI_LEFT       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROI_TOP        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROI_WIDTH      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROI_HEIGHT     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LUMA_THRESHOLD = 3'd6;

  localparam logic [SIZE_W-1:0]  FRAME_WIDTH_RESET    = 13'd640;
  localparam logic [SIZE_W-1:0]  FRAME_HEIGHT_RESET   = 13'd480;
  localparam logic [POS_W-1:0]   ROI_LEFT_RESET       = 12'd0;
  localparam logic [POS_W-1:0]   ROI_TOP_RESET        = 12'd0;
  localparam logic [SIZE_W-1:0]  ROI_WIDTH_RESET      = 13'd1;
  localparam logic [SIZE_W-1:0]  ROI_HEIGHT_RESET     = 13'd1;
  localparam logic [LEVEL_W-1:0] LUMA_THRESHOLD_RESET = 8'd120;

  localparam logic [SUM_W-1:0] LUMA_WR  = 18'd299;
  localparam logic [SUM_W-1:0] LUMA_WG  = 18'd587;
  localparam logic [SUM_W-1:0] LUMA_WB  = 18'd114;
  localparam logic [SUM_W-1:0] LUMA_DIV = 18'd1000;

  localparam logic [LEVEL_W-1:0] LEVEL_BLACK = 8'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_WHITE = 8'd255;
  localparam logic [TALLY_W-1:0] TALLY_MAX   = '1;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } ltrc_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] binary_level;
    logic [TALLY_W-1:0] black_in_region;
    logic               frame_end;
  } ltrc_out_t;

  typedef struct packed {
    logic [SIZE_W-1:0] col_last;
    logic [SIZE_W-1:0] row_last;
    logic [SIZE_W-1:0] roi_x0;
    logic [SIZE_W-1:0] roi_x1;
    logic [SIZE_W-1:0] roi_y0;
    logic [SIZE_W-1:0] roi_y1;
    logic [SUM_W-1:0]  thr_scaled;
  } ltrc_bounds_t;

endpackage

// ----- rtl/luma_threshold_roi_counter_core.sv -----
// ----------------------------------------------------------------------------
// luma_threshold_roi_counter_core
// Binarizes a raster RGB pixel stream at a luma threshold and counts black
// pixels inside a region of interest clamped to the frame. One pixel per
// clock sustained while the output is not stalled; each pixel passes an
// input register and then a result register before it is presented. Each
// result carries the level (0 or 255), the running black count of the frame
// including this pixel, and a flag on the last pixel of the frame, after
// which position and count clear. Register writes over APB pass the
// configuration register and then the bounds register before taking effect.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module luma_threshold_roi_counter_core #(
  parameter int MAX_SIDE = ltrc_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ltrc_pkg::ltrc_in_t           pixel,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  output ltrc_pkg::ltrc_out_t          result,
  output logic                         result_valid,
  input  logic                         result_stall,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ltrc_pkg::PADDR_W-1:0] paddr,
  input  logic [ltrc_pkg::PDATA_W-1:0] pwdata,
  output logic [ltrc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import ltrc_pkg::*;

  localparam int SIDE_LIMIT = (MAX_SIDE > (2 ** SIZE_W) - 1) ? 2 ** SIZE_W : MAX_SIDE;
  localparam int PW = $clog2(SIDE_LIMIT);

  ltrc_bounds_t bounds;

  logic     s1_valid;
  ltrc_in_t s1_pix;
  logic     advance;
  logic     accept;

  logic [PW-1:0]      col;
  logic [PW-1:0]      row;
  logic [TALLY_W-1:0] tally;
  logic [PW-1:0]      col_next;
  logic [PW-1:0]      row_next;
  logic [TALLY_W-1:0] tally_next;

  logic [SUM_W-1:0]   luma_sum;
  logic               black;
  logic               in_roi;
  logic               row_end;
  logic               frame_done;
  logic [SIZE_W-1:0]  col_ext;
  logic [SIZE_W-1:0]  row_ext;
  logic [TALLY_W-1:0] tally_count;
  ltrc_out_t          result_next;

  ltrc_cfg_regs #(
    .MAX_SIDE (MAX_SIDE)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bounds  (bounds)
  );

  assign advance     = s1_valid && (!result_valid || !result_stall);
  assign pixel_stall = rst || (s1_valid && !advance);
  assign accept      = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pixel;
    end
  end

  always_comb begin
    luma_sum = SUM_W'(s1_pix.red) * LUMA_WR
             + SUM_W'(s1_pix.green) * LUMA_WG
             + SUM_W'(s1_pix.blue) * LUMA_WB;
    black    = luma_sum < bounds.thr_scaled;

    col_ext = SIZE_W'(col);
    row_ext = SIZE_W'(row);
    in_roi  = (col_ext >= bounds.roi_x0) && (col_ext < bounds.roi_x1) &&
              (row_ext >= bounds.roi_y0) && (row_ext < bounds.roi_y1);
    row_end    = col_ext >= bounds.col_last;
    frame_done = row_end && (row_ext >= bounds.row_last);

    tally_count = (black && in_roi && (tally != TALLY_MAX)) ?
                  tally + TALLY_W'(1) : tally;

    result_next.binary_level    = black ? LEVEL_BLACK : LEVEL_WHITE;
    result_next.black_in_region = tally_count;
    result_next.frame_end       = frame_done;

    if (frame_done) begin
      col_next   = '0;
      row_next   = '0;
      tally_next = '0;
    end else if (row_end) begin
      col_next   = '0;
      row_next   = row + PW'(1);
      tally_next = tally_count;
    end else begin
      col_next   = col + PW'(1);
      row_next   = row;
      tally_next = tally_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      tally <= '0;
    end else if (advance) begin
      col   <= col_next;
      row   <= row_next;
      tally <= tally_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !pixel_stall)
    else $error("input stalled with an empty input register");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && frame_done) |=> (col == '0 && row == '0 && tally == '0))
    else $error("position or tally not cleared after frame end");

  a_tally_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> (tally == $past(tally) || tally == $past(tally) + TALLY_W'(1) ||
                 tally == '0))
    else $error("tally moved by more than one");

  a_level_codes: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.binary_level == LEVEL_BLACK ||
                      result.binary_level == LEVEL_WHITE))
    else $error("binary level is neither black nor white");
`endif

endmodule

// ----- rtl/ltrc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltrc_cfg_regs
// APB register file; registers the clamped frame and region bounds and the
// luma threshold scaled to the weighted-sum domain.
// ----------------------------------------------------------------------------
module ltrc_cfg_regs #(
  parameter int MAX_SIDE = ltrc_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ltrc_pkg::PADDR_W-1:0] paddr,
  input  logic [ltrc_pkg::PDATA_W-1:0] pwdata,
  output logic [ltrc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output ltrc_pkg::ltrc_bounds_t       bounds
);
  import ltrc_pkg::*;

  localparam logic [SIZE_W-1:0] SIDE_CAP =
    SIZE_W'((MAX_SIDE > (2 ** SIZE_W) - 1) ? (2 ** SIZE_W) - 1 : MAX_SIDE);

  logic [SIZE_W-1:0]  frame_width;
  logic [SIZE_W-1:0]  frame_height;
  logic [POS_W-1:0]   roi_left;
  logic [POS_W-1:0]   roi_top;
  logic [SIZE_W-1:0]  roi_width;
  logic [SIZE_W-1:0]  roi_height;
  logic [LEVEL_W-1:0] luma_threshold;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [SIZE_W-1:0] x_room;
  logic [SIZE_W-1:0] y_room;
  logic [SIZE_W-1:0] x_span;
  logic [SIZE_W-1:0] y_span;
  ltrc_bounds_t      bounds_next;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= FRAME_WIDTH_RESET;
      frame_height   <= FRAME_HEIGHT_RESET;
      roi_left       <= ROI_LEFT_RESET;
      roi_top        <= ROI_TOP_RESET;
      roi_width      <= ROI_WIDTH_RESET;
      roi_height     <= ROI_HEIGHT_RESET;
      luma_threshold <= LUMA_THRESHOLD_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:    frame_width    <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= pwdata[SIZE_W-1:0];
        REG_ROI_LEFT:       roi_left       <= pwdata[POS_W-1:0];
        REG_ROI_TOP:        roi_top        <= pwdata[POS_W-1:0];
        REG_ROI_WIDTH:      roi_width      <= pwdata[SIZE_W-1:0];
        REG_ROI_HEIGHT:     roi_height     <= pwdata[SIZE_W-1:0];
        REG_LUMA_THRESHOLD: luma_threshold <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:    prdata = PDATA_W'(frame_width);
      REG_FRAME_HEIGHT:   prdata = PDATA_W'(frame_height);
      REG_ROI_LEFT:       prdata = PDATA_W'(roi_left);
      REG_ROI_TOP:        prdata = PDATA_W'(roi_top);
      REG_ROI_WIDTH:      prdata = PDATA_W'(roi_width);
      REG_ROI_HEIGHT:     prdata = PDATA_W'(roi_height);
      REG_LUMA_THRESHOLD: prdata = PDATA_W'(luma_threshold);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    w_eff = (frame_width == '0) ? SIZE_W'(1) :
            (frame_width > SIDE_CAP) ? SIDE_CAP : frame_width;
    h_eff = (frame_height == '0) ? SIZE_W'(1) :
            (frame_height > SIDE_CAP) ? SIDE_CAP : frame_height;

    bounds_next.col_last = w_eff - SIZE_W'(1);
    bounds_next.row_last = h_eff - SIZE_W'(1);

    bounds_next.roi_x0 = (SIZE_W'(roi_left) > bounds_next.col_last) ?
                         bounds_next.col_last : SIZE_W'(roi_left);
    bounds_next.roi_y0 = (SIZE_W'(roi_top) > bounds_next.row_last) ?
                         bounds_next.row_last : SIZE_W'(roi_top);

    x_room = w_eff - bounds_next.roi_x0;
    y_room = h_eff - bounds_next.roi_y0;
    x_span = (roi_width == '0) ? SIZE_W'(1) :
             (roi_width > x_room) ? x_room : roi_width;
    y_span = (roi_height == '0) ? SIZE_W'(1) :
             (roi_height > y_room) ? y_room : roi_height;

    bounds_next.roi_x1 = bounds_next.roi_x0 + x_span;
    bounds_next.roi_y1 = bounds_next.roi_y0 + y_span;

    bounds_next.thr_scaled = SUM_W'(luma_threshold) * LUMA_DIV;
  end

  always_ff @(posedge clk) begin
    bounds <= bounds_next;
  end

endmodule
